// ----- rtl/kdhm_pkg.sv -----
`default_nettype none
package kdhm_pkg;

	// Input sample format: Q1.15
	localparam int SAMPLE_W = 16;
	localparam int FRAC_W = SAMPLE_W - 1;
	localparam int DEADBAND_W = 15;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 15'd1638;

	// cos(30 deg) in Q.16
	localparam int COS30_Q16 = 56756;

	// Wheel sums and powers in Q.16, 19 bits signed
	localparam int PW = 19;
	// Correction in Q.16
	localparam int CW = SAMPLE_W + 1;
	// Square root: radicand x^2+y^2 in Q.32, root in Q.16
	localparam int RADW = 2 * SAMPLE_W + 2;
	localparam int MAGW = RADW / 2;
	localparam int REMW = RADW + 1;

	// Numerator, its magnitude, denominator magnitude, scaled dividend
	localparam int NW = 38;
	localparam int AW = NW - 1;
	localparam int DW = PW + 16;
	localparam int QW = 7;
	localparam int TW = AW + QW;

	localparam int MOTOR_W = 8;
	localparam logic [QW-1:0] FULL_SCALE = 7'd127;

	// One input beat, last field in the lowest bits
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] heading_correction;
		logic signed [SAMPLE_W-1:0] rotation;
		logic signed [SAMPLE_W-1:0] trans_y;
		logic signed [SAMPLE_W-1:0] trans_x;
	} cmd_t;

	// Values that travel beside the square root
	typedef struct packed {
		logic [2:0][PW-1:0] p;
		logic signed [CW-1:0] corr;
		logic open_loop;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [RADW-1:0] rad;
	} sq_in_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [MAGW-1:0] root;
		side_t side;
	} sq_t;

	// Unsigned division job per wheel, shared denominator
	typedef struct packed {
		logic [2:0][AW-1:0] an;
		logic [2:0] neg;
		logic [DW-1:0] ad;
		logic open_loop;
	} div_in_t;

	typedef struct packed {
		logic heading_reset;
		logic [MOTOR_W-1:0] back_drive_reverse;
		logic [MOTOR_W-1:0] back_drive;
		logic [MOTOR_W-1:0] right_drive;
		logic [MOTOR_W-1:0] left_drive;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/kdhm_front.sv -----
`default_nettype none
module kdhm_front import kdhm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [DEADBAND_W-1:0] deadband,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire cmd_t                  in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output sq_in_t                     out_data
);

	logic vld_s1;
	logic en;
	sq_in_t nxt;
	sq_in_t data_s1;
	logic signed [34:0] sum0, sum1, sum2;
	logic signed [31:0] xx, yy;
	logic [31:0] ss;
	logic [SAMPLE_W:0] rabs;

	assign en = !vld_s1 || out_ready;
	assign in_ready = en;

	// Project onto the wheel axes, square the translation, test the deadband
	always_comb begin
		sum0 = 35'(in_data.trans_x) * 35'sd56756 + (35'(in_data.trans_y) <<< 15)
			+ (35'(in_data.rotation) <<< 16);
		sum1 = (35'sd0 - 35'(in_data.trans_x) * 35'sd56756) + (35'(in_data.trans_y) <<< 15)
			+ (35'(in_data.rotation) <<< 16);
		sum2 = (35'(in_data.rotation) - 35'(in_data.trans_y)) <<< 16;
		xx = 32'(in_data.trans_x) * 32'(in_data.trans_x);
		yy = 32'(in_data.trans_y) * 32'(in_data.trans_y);
		ss = 32'(xx) + 32'(yy);
		rabs = in_data.rotation[SAMPLE_W-1] ? 17'(17'sd0 - 17'(in_data.rotation))
			: 17'(in_data.rotation);
		nxt.side.p[0] = PW'(sum0 >>> FRAC_W);
		nxt.side.p[1] = PW'(sum1 >>> FRAC_W);
		nxt.side.p[2] = PW'(sum2 >>> FRAC_W);
		nxt.side.corr = CW'(in_data.heading_correction) <<< 1;
		nxt.side.open_loop = rabs > {2'b00, deadband};
		nxt.rad = {ss, 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data = data_s1;

endmodule
`default_nettype wire

// ----- rtl/kdhm_sqrt.sv -----
`default_nettype none
module kdhm_sqrt import kdhm_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire sq_in_t in_data,
	output logic        out_valid,
	input  wire logic   out_ready,
	output sq_t         out_data
);

	// One root bit per stage, most significant first
	sq_t sq_s [MAGW];
	logic vld_s [MAGW];
	logic [MAGW:0] en;

	assign en[MAGW] = out_ready;
	assign in_ready = en[0];

	for (genvar k = 0; k < MAGW; k++) begin : g_stage
		localparam int B = MAGW - 1 - k;
		sq_t cur;
		sq_t nxt;
		logic cur_v;
		logic [REMW-1:0] trial;

		if (k == 0) begin : g_first
			assign cur = '{rem: REMW'(in_data.rad), root: '0, side: in_data.side};
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur = sq_s[k-1];
			assign cur_v = vld_s[k-1];
		end

		assign en[k] = !vld_s[k] || en[k+1];

		// Try setting this bit: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		always_comb begin
			trial = (REMW'(cur.root) << (B + 1)) + (REMW'(1) << (2 * B));
			nxt = cur;
			if (cur.rem >= trial) begin
				nxt.rem = cur.rem - trial;
				nxt.root = cur.root | (MAGW'(1) << B);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				sq_s[k] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[MAGW-1];
	assign out_data = sq_s[MAGW-1];

`ifndef ASSERT_OFF
	// Floor root: remainder never reaches 2*root + 1
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.rem <= REMW'({out_data.root, 1'b0}))
		else $error("square root remainder too large");
`endif

endmodule
`default_nettype wire

// ----- rtl/kdhm_mix.sv -----
`default_nettype none
module kdhm_mix import kdhm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sq_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output div_in_t   out_data
);

	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	logic signed [NW-1:0] pm_s1 [3];
	logic signed [PW-1:0] dq_s1;
	logic signed [CW-1:0] corr_s1;
	logic [2:0][PW-1:0] p_s1;
	logic open_s1;

	logic signed [NW-1:0] pm_s2 [3];
	logic signed [NW-1:0] cd_s2;
	logic signed [PW-1:0] dq_s2;
	logic [2:0][PW-1:0] p_s2;
	logic open_s2;

	div_in_t data_s3;

	logic signed [PW-1:0] p0, p1, p2, mx;
	logic signed [NW-1:0] pm_nx [3];
	logic signed [NW-1:0] n_nx [3];
	logic [PW-1:0] dq_abs;
	div_in_t nx3;

	assign en3 = !vld_s3 || out_ready;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	// Stage 1: signed maximum and wheel sums times magnitude
	always_comb begin
		p0 = $signed(in_data.side.p[0]);
		p1 = $signed(in_data.side.p[1]);
		p2 = $signed(in_data.side.p[2]);
		mx = p0;
		if (p1 > mx) mx = p1;
		if (p2 > mx) mx = p2;
		for (int i = 0; i < 3; i++) begin
			pm_nx[i] = NW'($signed(in_data.side.p[i])) * NW'($signed({1'b0, in_data.root}));
		end
	end

	// Stage 3: select the path, split into magnitude and sign
	always_comb begin
		dq_abs = dq_s2[PW-1] ? PW'(-dq_s2) : PW'(dq_s2);
		for (int i = 0; i < 3; i++) begin
			n_nx[i] = open_s2 ? NW'($signed(p_s2[i])) : pm_s2[i] + cd_s2;
			nx3.an[i] = n_nx[i][NW-1] ? AW'(-n_nx[i]) : AW'(n_nx[i]);
			nx3.neg[i] = n_nx[i][NW-1] ^ (!open_s2 && dq_s2[PW-1]);
		end
		nx3.ad = open_s2 ? DW'(1) << 16 : {dq_abs, 16'h0000};
		nx3.open_loop = open_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pm_s1 <= pm_nx;
			dq_s1 <= (mx != '0) ? mx : PW'(1) <<< 16;
			corr_s1 <= in_data.side.corr;
			p_s1 <= in_data.side.p;
			open_s1 <= in_data.side.open_loop;
		end
		// Stage 2: correction times divisor
		if (en2) begin
			pm_s2 <= pm_s1;
			cd_s2 <= NW'(corr_s1) * NW'(dq_s1);
			dq_s2 <= dq_s1;
			p_s2 <= p_s1;
			open_s2 <= open_s1;
		end
		if (en3) begin
			data_s3 <= nx3;
		end
	end

	assign out_valid = vld_s3;
	assign out_data = data_s3;

endmodule
`default_nettype wire

// ----- rtl/kdhm_div.sv -----
`default_nettype none
module kdhm_div import kdhm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire div_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output res_t         out_data
);

	localparam int NS = QW + 2;

	typedef struct packed {
		logic [2:0][TW-1:0] rem;
		logic [2:0][QW-1:0] q;
		logic [2:0] sat;
		logic [2:0] neg;
		logic [DW-1:0] ad;
		logic open_loop;
	} dv_t;

	dv_t dv_s [QW+1];
	logic vld_s [NS];
	logic [NS:0] en;
	res_t out_s;
	res_t res_nx;
	logic [QW-1:0] mag [3];
	logic [MOTOR_W-1:0] drv [3];

	assign en[NS] = out_ready;
	assign in_ready = en[0];

	for (genvar k = 0; k <= QW; k++) begin : g_stage
		dv_t nxt;
		logic cur_v;

		assign en[k] = !vld_s[k] || en[k+1];

		if (k == 0) begin : g_first
			assign cur_v = in_valid;
			// Saturate when |n| >= |d|, else divide 127*|n| by |d|
			always_comb begin
				nxt.ad = in_data.ad;
				nxt.neg = in_data.neg;
				nxt.open_loop = in_data.open_loop;
				nxt.q = '0;
				for (int i = 0; i < 3; i++) begin
					nxt.sat[i] = in_data.an[i] >= AW'(in_data.ad);
					nxt.rem[i] = (TW'(in_data.an[i]) << QW) - TW'(in_data.an[i]);
				end
			end
		end else begin : g_next
			localparam int J = QW - k;
			assign cur_v = vld_s[k-1];
			// Restoring step for quotient bit J
			always_comb begin
				nxt = dv_s[k-1];
				for (int i = 0; i < 3; i++) begin
					if (dv_s[k-1].rem[i] >= (TW'(dv_s[k-1].ad) << J)) begin
						nxt.rem[i] = dv_s[k-1].rem[i] - (TW'(dv_s[k-1].ad) << J);
						nxt.q[i][J] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				dv_s[k] <= nxt;
			end
		end
	end

	// Apply saturation and sign
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = dv_s[QW].sat[i] ? FULL_SCALE : dv_s[QW].q[i];
			drv[i] = dv_s[QW].neg[i] ? MOTOR_W'(8'd0 - {1'b0, mag[i]}) : {1'b0, mag[i]};
		end
		res_nx.left_drive = drv[0];
		res_nx.right_drive = drv[1];
		res_nx.back_drive = drv[2];
		res_nx.back_drive_reverse = MOTOR_W'(8'd0 - drv[2]);
		res_nx.heading_reset = dv_s[QW].open_loop;
	end

	assign en[NS-1] = !vld_s[NS-1] || en[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[NS-1] <= 1'b0;
		end else if (en[NS-1]) begin
			vld_s[NS-1] <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			out_s <= res_nx;
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_data = out_s;

endmodule
`default_nettype wire

// ----- rtl/kiwi_drive_heading_hold_mixer.sv -----
`default_nettype none
// Three-wheel holonomic mixer with heading hold. One command beat may enter every clock
// while the output is not held; each result passes 1 projection stage, 17 square-root
// stages at one root bit each, 3 mixing stages and 9 divide and output stages, the 7
// quotient bits of the power scaling setting that last count. Every stage has its own
// valid bit and advances when the next one is free, so a held output stalls only as
// far back as the pipeline is full and empty slots keep absorbing new beats. The user
// writes the deadband register on cfg_valid only while the pipeline is idle; the block
// itself does not enforce it, and cfg_ready is always high.
module kiwi_drive_heading_hold_mixer import kdhm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// trans_x[15:0], trans_y[31:16], rotation[47:32], heading_correction[63:48]
	input  wire logic [63:0]           s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// left_drive[7:0], right_drive[15:8], back_drive[23:16], back_drive_reverse[31:24]
	output logic [31:0]                m_axis_tdata,
	// heading_reset[0]
	output logic [0:0]                 m_axis_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [DEADBAND_W-1:0] cfg_data
);

	logic [DEADBAND_W-1:0] deadband_q;
	logic f_valid, f_ready, q_valid, q_ready, x_valid, x_ready;
	sq_in_t f_data;
	sq_t q_data;
	div_in_t x_data;
	res_t res;

	// Hold the deadband register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_valid) begin
			deadband_q <= cfg_data;
		end
	end

	kdhm_front u_front (
		.clk, .arst_n,
		.deadband  (deadband_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (cmd_t'(s_axis_tdata)),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	kdhm_sqrt u_sqrt (
		.clk, .arst_n,
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	kdhm_mix u_mix (
		.clk, .arst_n,
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_data   (q_data),
		.out_valid (x_valid),
		.out_ready (x_ready),
		.out_data  (x_data)
	);

	kdhm_div u_div (
		.clk, .arst_n,
		.in_valid  (x_valid),
		.in_ready  (x_ready),
		.in_data   (x_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = {res.back_drive_reverse, res.back_drive, res.right_drive,
		res.left_drive};
	assign m_axis_tuser = res.heading_reset;

`ifndef ASSERT_OFF
	a_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:24] == 8'(8'd0 - m_axis_tdata[23:16]))
		else $error("reverse back drive is not the negated back drive");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80 && m_axis_tdata[15:8] != 8'h80
			&& m_axis_tdata[23:16] != 8'h80))
		else $error("drive command beyond full scale");
`endif

endmodule
`default_nettype wire

// ----- tb/kdhm_checker.sv -----
`default_nettype none
// Watches the command, result and deadband channels, predicts each result
// from the accepted command and compares in arrival order.
module kdhm_checker import kdhm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [63:0]           s_axis_tdata,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [31:0]           m_axis_tdata,
	input  wire logic [0:0]            m_axis_tuser,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [DEADBAND_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending
);

	logic [DEADBAND_W-1:0] deadband;
	res_t                  wheel_q[$];

	// floor of the square root
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// trunc(127 * n / d) saturated to full scale, then cut to 8 bits
	function automatic logic [MOTOR_W-1:0] to_motor(longint n, longint d);
		longint unsigned an;
		longint unsigned ad;
		longint          m;
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		m = (an >= ad) ? 127 : longint'((127 * an) / ad);
		if ((n < 0) != (d < 0))
			m = -m;
		return m[MOTOR_W-1:0];
	endfunction

	function automatic res_t mix_wheels(cmd_t c, logic [DEADBAND_W-1:0] db);
		res_t            o;
		longint          x, y, r, corr, mx, dq, mag, absr;
		longint          p[3];
		logic [MOTOR_W-1:0] w[3];
		longint unsigned ss;
		x = longint'(c.trans_x);
		y = longint'(c.trans_y);
		r = longint'(c.rotation);
		p[0] = (x * COS30_Q16 + y * 32768 + r * 65536) >>> FRAC_W;
		p[1] = (-x * COS30_Q16 + y * 32768 + r * 65536) >>> FRAC_W;
		p[2] = (-y * 65536 + r * 65536) >>> FRAC_W;
		absr = (r < 0) ? -r : r;
		o.heading_reset = absr > longint'(db);
		if (o.heading_reset) begin
			for (int i = 0; i < 3; i++)
				w[i] = to_motor(p[i], 65536);
		end else begin
			ss = (x * x + y * y) << 2;
			mag = longint'(root_floor(ss));
			corr = (longint'(c.heading_correction) * 65536) >>> FRAC_W;
			mx = p[0];
			if (p[1] > mx) mx = p[1];
			if (p[2] > mx) mx = p[2];
			dq = (mx != 0) ? mx : 65536;
			for (int i = 0; i < 3; i++)
				w[i] = to_motor(p[i] * mag + corr * dq, dq * 65536);
		end
		o.left_drive = w[0];
		o.right_drive = w[1];
		o.back_drive = w[2];
		o.back_drive_reverse = -w[2];
		return o;
	endfunction

	assign pending = wheel_q.size();

	// track the register, predict on each command beat, check each result beat
	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		res_t got;
		int   errs;
		if (!arst_n) begin
			deadband <= DEADBAND_RESET;
			errors <= 0;
			wheel_q.delete();
		end else begin
			errs = errors;
			if (cfg_valid && cfg_ready)
				deadband <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				wheel_q.push_back(mix_wheels(cmd_t'(s_axis_tdata), deadband));
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser, m_axis_tdata};
				if (wheel_q.size() == 0) begin
					$error("result beat with nothing expected: %h", got);
					errs++;
				end else begin
					exp_r = wheel_q.pop_front();
					if (got.left_drive !== exp_r.left_drive) begin
						$error("left_drive exp %0d got %0d", $signed(exp_r.left_drive),
							$signed(got.left_drive));
						errs++;
					end
					if (got.right_drive !== exp_r.right_drive) begin
						$error("right_drive exp %0d got %0d", $signed(exp_r.right_drive),
							$signed(got.right_drive));
						errs++;
					end
					if (got.back_drive !== exp_r.back_drive) begin
						$error("back_drive exp %0d got %0d", $signed(exp_r.back_drive),
							$signed(got.back_drive));
						errs++;
					end
					if (got.back_drive_reverse !== exp_r.back_drive_reverse) begin
						$error("back_drive_reverse exp %0d got %0d",
							$signed(exp_r.back_drive_reverse),
							$signed(got.back_drive_reverse));
						errs++;
					end
					if (got.heading_reset !== exp_r.heading_reset) begin
						$error("heading_reset exp %0b got %0b", exp_r.heading_reset,
							got.heading_reset);
						errs++;
					end
				end
			end
			errors <= errs;
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;
	import kdhm_pkg::*;

	localparam int LATENCY = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [63:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [31:0]           m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [DEADBAND_W-1:0] cfg_data;
	int                    errors;
	int                    pending;
	int                    quiet_cycles;
	bit                    steady;
	int                    hold_reqs;
	int                    hold_done;
	int                    hold_left;
	logic [DEADBAND_W-1:0] db_now;

	kiwi_drive_heading_hold_mixer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	kdhm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: random backpressure, one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_reqs) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 17);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic send_cmd(logic signed [15:0] tx, logic signed [15:0] ty,
		logic signed [15:0] rot, logic signed [15:0] corr);
		cmd_t c;
		c.trans_x = tx;
		c.trans_y = ty;
		c.rotation = rot;
		c.heading_correction = corr;
		while (!steady && $urandom_range(99) < 17) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// write the deadband once the pipeline has drained
	task automatic set_deadband(logic [DEADBAND_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		db_now = v;
	endtask

	// mostly heading-hold commands, the rest anywhere in range
	task automatic send_random(int count);
		logic signed [15:0] rot;
		int                 span;
		for (int i = 0; i < count; i++) begin
			span = int'(db_now);
			if ($urandom_range(99) < 60)
				rot = 16'($urandom_range(2 * span) - span);
			else
				rot = 16'($urandom);
			send_cmd(16'($urandom), 16'($urandom), rot,
				$urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2000) - 1000));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		clk = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		hold_reqs = 0;
		db_now = DEADBAND_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, deadband edges, zero and negative maximum
		send_cmd(0, 0, 0, 0);
		send_cmd(16'sh7fff, 16'sh7fff, 0, 16'sh7fff);
		send_cmd(-16'sh8000, -16'sh8000, 0, -16'sh8000);
		send_cmd(16'sh7fff, -16'sh8000, 0, 0);
		send_cmd(-16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_cmd(0, 0, -16'sh8000, 0);
		send_cmd(1000, 2000, 1638, 500);
		send_cmd(1000, 2000, -1638, -500);
		send_cmd(1000, 2000, 1639, 500);
		send_cmd(1000, 2000, -1639, 500);
		send_cmd(0, 0, -100, 300);
		send_cmd(0, 0, 100, -300);
		send_cmd(0, 16'sh4000, -1000, 0);
		send_cmd(16'sh7fff, 0, 0, -16'sh8000);
		send_cmd(0, 16'sh7fff, 16'sh7fff, 0);
		send_cmd(-1, -1, -1, -1);
		send_cmd(1, 1, 1, 1);
		send_cmd(16'sh5555, -16'sh2aab, 16'sh0aaa, 16'sh5555);

		send_random(350);
		// wait out every result before going on
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
		send_random(50);

		set_deadband(0);
		send_cmd(0, 0, 0, 100);
		send_cmd(500, -500, 1, 0);
		send_random(300);

		set_deadband(15'h7fff);
		send_cmd(100, 200, 16'sh7fff, 0);
		send_cmd(100, 200, -16'sh7fff, 0);
		send_cmd(100, 200, -16'sh8000, 0);
		// back-to-back with no idling, then a long hold-off under load
		steady = 1'b1;
		send_random(200);
		steady = 1'b0;
		hold_reqs <= hold_reqs + 1;
		send_random(300);

		set_deadband(15'($urandom_range(15'h7fff)));
		send_random(250);

		set_deadband(DEADBAND_RESET);
		send_random(230);

		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/kdhm_pkg.sv
rtl/kdhm_front.sv
rtl/kdhm_sqrt.sv
rtl/kdhm_mix.sv
rtl/kdhm_div.sv
rtl/kiwi_drive_heading_hold_mixer.sv
tb/kdhm_checker.sv
tb/tb_top.sv
